// ===== hw/rtl/sva_pkg.sv =====
package sva_pkg;

    localparam int MAX_VOICES_DEF = 16;

    localparam int VC_W     = 5;
    localparam int NOTE_W   = 7;
    localparam int STAMP_W  = 32;
    localparam int TARGET_W = 4;

    localparam logic [VC_W-1:0]    VOICE_COUNT_RST = 5'd12;
    localparam logic [STAMP_W-1:0] STAMP_MAX       = '1;

    typedef enum logic [1:0] {
        CMD_NOTE_ON   = 2'd0,
        CMD_NOTE_OFF  = 2'd1,
        CMD_BROADCAST = 2'd2,
        CMD_IGNORE    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_FINISH = 2'd2
    } state_t;

endpackage

// ===== hw/rtl/sva_ram.sv =====
module sva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/synth_voice_allocator_top.sv =====
// Polyphonic voice allocator with oldest-note stealing. A note-on request takes the first free
// voice or steals the busy voice with the smallest age stamp; a note-off request frees the
// first busy voice that holds the note; broadcast requests go to every voice. Note and age
// of each voice sit in one RAM with a single registered read port, which a sequencer walks
// one voice per cycle over the active voices (the voice count clamped to 1..MAX_VOICES),
// stopping early when a free voice or a matching note turns up; broadcast and ignored
// requests skip the walk. A request waits in the finish state for as long as the previous
// result is still held in the output register. The result sits in an output register, so
// the next request can be taken while it waits.
module synth_voice_allocator_top #(
    parameter int MAX_VOICES = sva_pkg::MAX_VOICES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [sva_pkg::VC_W-1:0]       cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     command,
    input  logic [sva_pkg::NOTE_W-1:0]     note,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sva_pkg::TARGET_W-1:0]   target_voice,
    output logic                           to_all_voices,
    output logic                           forwarded,
    output logic                           found
);

    localparam int VIDX_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int CNT_W  = $clog2(MAX_VOICES + 1);
    localparam int RAM_W  = sva_pkg::NOTE_W + sva_pkg::STAMP_W;
    localparam int CMP_W  = (CNT_W > sva_pkg::VC_W) ? CNT_W : sva_pkg::VC_W;

    sva_pkg::state_t state_reg, state_next;
    sva_pkg::cmd_t   cmd_reg, cmd_next;

    logic [sva_pkg::VC_W-1:0]    voice_count_reg;
    logic [sva_pkg::NOTE_W-1:0]  note_reg, note_next;
    logic [CNT_W-1:0]            n_reg, n_next;
    logic [CNT_W-1:0]            idx_reg, idx_next;
    logic                        cmp_valid_reg, cmp_valid_next;
    logic [VIDX_W-1:0]           cmp_idx_reg, cmp_idx_next;
    logic [sva_pkg::STAMP_W-1:0] oldest_reg, oldest_next;
    logic [VIDX_W-1:0]           pick_reg, pick_next;
    logic                        found_reg, found_next;
    logic [MAX_VOICES-1:0]       busy_reg, busy_next;
    logic [sva_pkg::STAMP_W-1:0] stamp_reg, stamp_next;

    logic                         out_valid_reg, out_valid_next;
    logic [sva_pkg::TARGET_W-1:0] out_target_reg, out_target_next;
    logic                         out_all_reg, out_all_next;
    logic                         out_fwd_reg, out_fwd_next;
    logic                         out_found_reg, out_found_next;

    logic                         ram_we;
    logic [RAM_W-1:0]             ram_wdata;
    logic [RAM_W-1:0]             ram_rdata;
    logic [sva_pkg::NOTE_W-1:0]   rd_note;
    logic [sva_pkg::STAMP_W-1:0]  rd_age;

    logic [CMP_W-1:0]             vc_ext;
    logic [CNT_W-1:0]             n_clamp;
    logic [VIDX_W+sva_pkg::TARGET_W-1:0] pick_wide;
    logic                         cmp_last;
    logic                         cmp_busy;

    sva_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_VOICES)
    ) u_voice_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (pick_reg),
        .wr_data (ram_wdata),
        .rd_addr (idx_reg[VIDX_W-1:0]),
        .rd_data (ram_rdata)
    );

    assign ram_wdata = {note_reg, stamp_reg};
    assign rd_note   = ram_rdata[RAM_W-1:sva_pkg::STAMP_W];
    assign rd_age    = ram_rdata[sva_pkg::STAMP_W-1:0];

    // zero acts as one voice, anything above the limit acts as the limit
    assign vc_ext = CMP_W'(voice_count_reg);
    always_comb
    begin
        if (voice_count_reg == '0)
        begin
            n_clamp = CNT_W'(1);
        end
        else if (vc_ext > CMP_W'(MAX_VOICES))
        begin
            n_clamp = CNT_W'(MAX_VOICES);
        end
        else
        begin
            n_clamp = CNT_W'(vc_ext);
        end
    end

    assign pick_wide = (VIDX_W + sva_pkg::TARGET_W)'(pick_reg);
    assign cmp_last  = (CNT_W'(cmp_idx_reg) == (n_reg - CNT_W'(1)));
    assign cmp_busy  = busy_reg[cmp_idx_reg];

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        note_next       = note_reg;
        n_next          = n_reg;
        idx_next        = idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        oldest_next     = oldest_reg;
        pick_next       = pick_reg;
        found_next      = found_reg;
        busy_next       = busy_reg;
        stamp_next      = stamp_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_target_next = out_target_reg;
        out_all_next    = out_all_reg;
        out_fwd_next    = out_fwd_reg;
        out_found_next  = out_found_reg;
        ram_we          = 1'b0;

        case (state_reg)
            sva_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next       = sva_pkg::cmd_t'(command);
                    note_next      = note;
                    n_next         = n_clamp;
                    idx_next       = '0;
                    cmp_valid_next = 1'b0;
                    oldest_next    = sva_pkg::STAMP_MAX;
                    pick_next      = '0;
                    found_next     = 1'b0;
                    if (command inside {sva_pkg::CMD_NOTE_ON, sva_pkg::CMD_NOTE_OFF})
                    begin
                        state_next = sva_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = sva_pkg::ST_FINISH;
                    end
                end
            end

            sva_pkg::ST_SCAN:
            begin
                // read of voice idx is issued here, compared in the next cycle
                cmp_valid_next = (idx_reg < n_reg);
                cmp_idx_next   = idx_reg[VIDX_W-1:0];
                if (idx_reg < n_reg)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end

                if (cmp_valid_reg)
                begin
                    if (cmd_reg == sva_pkg::CMD_NOTE_ON)
                    begin
                        if (!cmp_busy)
                        begin
                            pick_next      = cmp_idx_reg;
                            found_next     = 1'b1;
                            cmp_valid_next = 1'b0;
                            state_next     = sva_pkg::ST_FINISH;
                        end
                        else
                        begin
                            if (rd_age < oldest_reg)
                            begin
                                oldest_next = rd_age;
                                pick_next   = cmp_idx_reg;
                            end
                            if (cmp_last)
                            begin
                                cmp_valid_next = 1'b0;
                                state_next     = sva_pkg::ST_FINISH;
                            end
                        end
                    end
                    else
                    begin
                        if (cmp_busy && (rd_note == note_reg))
                        begin
                            pick_next      = cmp_idx_reg;
                            found_next     = 1'b1;
                            cmp_valid_next = 1'b0;
                            state_next     = sva_pkg::ST_FINISH;
                        end
                        else if (cmp_last)
                        begin
                            cmp_valid_next = 1'b0;
                            state_next     = sva_pkg::ST_FINISH;
                        end
                    end
                end
            end

            sva_pkg::ST_FINISH:
            begin
                // state is committed only once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_target_next = '0;
                    out_all_next    = 1'b0;
                    out_fwd_next    = 1'b0;
                    out_found_next  = 1'b0;
                    case (cmd_reg)
                        sva_pkg::CMD_NOTE_ON:
                        begin
                            busy_next[pick_reg] = 1'b1;
                            ram_we              = 1'b1;
                            stamp_next          = stamp_reg + sva_pkg::STAMP_W'(1);
                            out_target_next     = pick_wide[sva_pkg::TARGET_W-1:0];
                            out_fwd_next        = 1'b1;
                            out_found_next      = found_reg;
                        end
                        sva_pkg::CMD_NOTE_OFF:
                        begin
                            if (found_reg)
                            begin
                                busy_next[pick_reg] = 1'b0;
                            end
                            out_target_next = pick_wide[sva_pkg::TARGET_W-1:0];
                            out_fwd_next    = 1'b1;
                            out_found_next  = found_reg;
                        end
                        sva_pkg::CMD_BROADCAST:
                        begin
                            out_all_next = 1'b1;
                            out_fwd_next = 1'b1;
                        end
                        default:
                        begin
                            out_fwd_next = 1'b0;
                        end
                    endcase
                    state_next = sva_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sva_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sva_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_count_reg <= sva_pkg::VOICE_COUNT_RST;
            cmd_reg         <= sva_pkg::CMD_IGNORE;
            n_reg           <= '0;
            idx_reg         <= '0;
            cmp_valid_reg   <= 1'b0;
            cmp_idx_reg     <= '0;
            found_reg       <= 1'b0;
            busy_reg        <= '0;
            stamp_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                voice_count_reg <= cfg_wr_data;
            end
            cmd_reg       <= cmd_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_idx_reg   <= cmp_idx_next;
            found_reg     <= found_next;
            busy_reg      <= busy_next;
            stamp_reg     <= stamp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        note_reg       <= note_next;
        oldest_reg     <= oldest_next;
        pick_reg       <= pick_next;
        out_target_reg <= out_target_next;
        out_all_reg    <= out_all_next;
        out_fwd_reg    <= out_fwd_next;
        out_found_reg  <= out_found_next;
    end

    assign in_ready      = (state_reg == sva_pkg::ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign target_voice  = out_target_reg;
    assign to_all_voices = out_all_reg;
    assign forwarded     = out_fwd_reg;
    assign found         = out_found_reg;

endmodule

// ===== bench/tb_synth_voice_allocator_top.sv =====
`timescale 1ns / 100ps

module tb_synth_voice_allocator_top;

    import sva_pkg::*;

    localparam int MAX_V       = MAX_VOICES_DEF;
    localparam int LIMIT_CYC   = 600000;
    localparam int SETTLE_CYC  = 24;
    localparam int HOLD_CYC    = 400;
    localparam int PHASE_REQS  = 200;
    localparam int PHASES      = 8;
    localparam int DIR_ROWS    = 22;

    typedef struct packed {
        logic [TARGET_W-1:0] voice;
        logic                bcast;
        logic                fwd;
        logic                found;
    } route_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [VC_W-1:0]   vc;
        cmd_t              cmd;
        logic [NOTE_W-1:0] note;
        bit                typed;
        route_t            want;
    } dir_row_t;

    // results that can be read straight off the spec
    localparam route_t R_DROP  = '{4'd0, 1'b0, 1'b0, 1'b0};
    localparam route_t R_BCAST = '{4'd0, 1'b1, 1'b1, 1'b0};
    localparam route_t R_MISS  = '{4'd0, 1'b0, 1'b1, 1'b0};
    localparam route_t R_FIRST = '{4'd0, 1'b0, 1'b1, 1'b1};

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [VC_W-1:0]     cfg_wr_data;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          command;
    logic [NOTE_W-1:0]   note;
    logic                out_valid;
    logic                out_ready;
    logic [TARGET_W-1:0] target_voice;
    logic                to_all_voices;
    logic                forwarded;
    logic                found;

    // allocator mirror
    logic [VC_W-1:0]     polyphony;
    bit                  voice_busy_m [MAX_V];
    logic [NOTE_W-1:0]   voice_note_m [MAX_V];
    logic [STAMP_W-1:0]  voice_age_m [MAX_V];
    logic [STAMP_W-1:0]  stamp_m;

    route_t              pending_routes [$];
    int                  err_cnt;
    int                  cycle_cnt;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    bit                  hold_req;
    dir_row_t            dir_rows [DIR_ROWS];

    synth_voice_allocator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .note          (note),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .target_voice  (target_voice),
        .to_all_voices (to_all_voices),
        .forwarded     (forwarded),
        .found         (found)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int active_voices();
        if (polyphony == 0)
            return 1;
        if (polyphony > MAX_V)
            return MAX_V;
        return int'(polyphony);
    endfunction

    function automatic route_t route_event(input cmd_t c, input logic [NOTE_W-1:0] n);
        route_t             r;
        int                 active;
        int                 pick;
        logic [STAMP_W-1:0] oldest;
        bit                 hit;
        r = '0;
        active = active_voices();
        pick = 0;
        hit = 1'b0;
        oldest = STAMP_MAX;
        case (c)
            CMD_NOTE_ON:
            begin
                // first free voice wins, otherwise the oldest stamp, first on ties
                for (int i = 0; i < active; i++)
                begin
                    if (!hit)
                    begin
                        if (!voice_busy_m[i])
                        begin
                            pick = i;
                            hit = 1'b1;
                        end
                        else if (voice_age_m[i] < oldest)
                        begin
                            oldest = voice_age_m[i];
                            pick = i;
                        end
                    end
                end
                voice_busy_m[pick] = 1'b1;
                voice_note_m[pick] = n;
                voice_age_m[pick] = stamp_m;
                stamp_m = stamp_m + 1'b1;
                r.voice = pick[TARGET_W-1:0];
                r.fwd = 1'b1;
                r.found = hit;
            end
            CMD_NOTE_OFF:
            begin
                r.fwd = 1'b1;
                for (int i = 0; i < active; i++)
                begin
                    if (!hit && voice_busy_m[i] && voice_note_m[i] == n)
                    begin
                        voice_busy_m[i] = 1'b0;
                        r.voice = i[TARGET_W-1:0];
                        r.found = 1'b1;
                        hit = 1'b1;
                    end
                end
            end
            CMD_BROADCAST:
            begin
                r.bcast = 1'b1;
                r.fwd = 1'b1;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_err(input string what, input int got, input int want);
        $display("ERROR cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
        err_cnt++;
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_req(input cmd_t c, input logic [NOTE_W-1:0] n, input bit typed,
                            input route_t want);
        route_t pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        command = c;
        note = n;
        do
            @(posedge clk);
        while (!in_ready);
        pred = route_event(c, n);
        pending_routes.push_back(typed ? want : pred);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending_routes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_polyphony(input logic [VC_W-1:0] v);
        cfg_wr_en = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        polyphony = v;
    endtask

    task automatic pick_request(output cmd_t c, output logic [NOTE_W-1:0] n);
        logic [NOTE_W-1:0] held [$];
        int                roll;
        roll = $urandom_range(99);
        n = NOTE_W'($urandom_range(127));
        for (int i = 0; i < active_voices(); i++)
            if (voice_busy_m[i])
                held.push_back(voice_note_m[i]);
        if (roll < 45)
        begin
            c = CMD_NOTE_ON;
            // narrow pool so the same note lands in several voices
            if ($urandom_range(9) < 3)
                n = NOTE_W'(60 + $urandom_range(7));
        end
        else if (roll < 75)
        begin
            c = CMD_NOTE_OFF;
            if (held.size() != 0)
                n = held[$urandom_range(held.size() - 1)];
        end
        else if (roll < 85)
            c = CMD_NOTE_OFF;
        else if (roll < 94)
            c = CMD_BROADCAST;
        else
            c = CMD_IGNORE;
    endtask

    // receiver side, with one long hold-off on request
    initial
    begin : recv_blk
        int  hold_left;
        bit  hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYC;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_blk
        route_t want;
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYC)
        begin
            $display("timeout at cycle %0d", cycle_cnt);
            $display("Mismatches found");
            $finish;
        end
        else if (rst_n && out_valid && out_ready)
        begin
            if (pending_routes.size() == 0)
                report_err("result with nothing pending, target_voice", int'(target_voice), 0);
            else
            begin
                want = pending_routes.pop_front();
                if (target_voice !== want.voice)
                    report_err("target_voice", int'(target_voice), int'(want.voice));
                if (to_all_voices !== want.bcast)
                    report_err("to_all_voices", int'(to_all_voices), int'(want.bcast));
                if (forwarded !== want.fwd)
                    report_err("forwarded", int'(forwarded), int'(want.fwd));
                if (found !== want.found)
                    report_err("found", int'(found), int'(want.found));
            end
        end
    end

    initial
    begin : main_blk
        logic [VC_W-1:0]   phase_vc [PHASES];
        cmd_t              c;
        logic [NOTE_W-1:0] n;
        int                sent;
        err_cnt = 0;
        cycle_cnt = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        command = CMD_IGNORE;
        note = '0;
        polyphony = VOICE_COUNT_RST;
        stamp_m = '0;
        for (int i = 0; i < MAX_V; i++)
        begin
            voice_busy_m[i] = 1'b0;
            voice_note_m[i] = '0;
            voice_age_m[i] = '0;
        end

        dir_rows = '{
            '{ROW_REQ, 5'd0,  CMD_IGNORE,    7'd127, 1'b1, R_DROP},
            '{ROW_REQ, 5'd0,  CMD_BROADCAST, 7'd0,   1'b1, R_BCAST},
            '{ROW_REQ, 5'd0,  CMD_NOTE_OFF,  7'd85,  1'b1, R_MISS},
            '{ROW_REQ, 5'd0,  CMD_NOTE_ON,   7'd0,   1'b1, R_FIRST},
            '{ROW_REQ, 5'd0,  CMD_NOTE_ON,   7'd127, 1'b0, R_DROP},
            '{ROW_REQ, 5'd0,  CMD_NOTE_OFF,  7'd127, 1'b0, R_DROP},
            '{ROW_CFG, 5'd0,  CMD_IGNORE,    7'd0,   1'b0, R_DROP},
            '{ROW_REQ, 5'd0,  CMD_NOTE_ON,   7'd42,  1'b0, R_DROP},
            '{ROW_REQ, 5'd0,  CMD_NOTE_OFF,  7'd0,   1'b1, R_MISS},
            '{ROW_CFG, 5'd31, CMD_IGNORE,    7'd0,   1'b0, R_DROP},
            '{ROW_REQ, 5'd0,  CMD_NOTE_ON,   7'd85,  1'b0, R_DROP},
            '{ROW_REQ, 5'd0,  CMD_NOTE_ON,   7'd85,  1'b0, R_DROP},
            '{ROW_REQ, 5'd0,  CMD_NOTE_OFF,  7'd85,  1'b0, R_DROP},
            '{ROW_REQ, 5'd0,  CMD_BROADCAST, 7'd127, 1'b1, R_BCAST},
            '{ROW_REQ, 5'd0,  CMD_IGNORE,    7'd0,   1'b1, R_DROP},
            '{ROW_CFG, 5'd17, CMD_IGNORE,    7'd0,   1'b0, R_DROP},
            '{ROW_REQ, 5'd0,  CMD_NOTE_ON,   7'd3,   1'b0, R_DROP},
            '{ROW_CFG, 5'd1,  CMD_IGNORE,    7'd0,   1'b0, R_DROP},
            '{ROW_REQ, 5'd0,  CMD_NOTE_ON,   7'd64,  1'b0, R_DROP},
            '{ROW_REQ, 5'd0,  CMD_NOTE_OFF,  7'd42,  1'b0, R_DROP},
            '{ROW_CFG, 5'd16, CMD_IGNORE,    7'd0,   1'b0, R_DROP},
            '{ROW_REQ, 5'd0,  CMD_NOTE_OFF,  7'd85,  1'b0, R_DROP}
        };
        phase_vc = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd2, 5'd0, 5'd17,
                     VC_W'($urandom_range(1, MAX_V))};

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_rows[r].kind == ROW_CFG)
            begin
                wait_idle();
                write_polyphony(dir_rows[r].vc);
            end
            else
                send_req(dir_rows[r].cmd, dir_rows[r].note, dir_rows[r].typed,
                         dir_rows[r].want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            write_polyphony(phase_vc[ph]);
            case (ph % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            // output held off while requests keep coming, so the input backs up
            if (ph == 4)
                hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_REQS)
            begin
                pick_request(c, n);
                send_req(c, n, 1'b0, R_DROP);
                if (c != CMD_IGNORE)
                    sent++;
            end
        end

        wait_idle();
        if (err_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sva_pkg.sv
hw/rtl/sva_ram.sv
hw/rtl/synth_voice_allocator_top.sv
bench/tb_synth_voice_allocator_top.sv
